// ===== rtl/positional_list_insert_remove_count_defines.svh =====
// Assertion macros used by the positional list datapath.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_COUNT_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_COUNT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define PLIRC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define PLIRC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/plirc_pkg.sv =====
// Shared types and constants of the positional list block.
// No dependencies.
`default_nettype none

package plirc_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (LEN_W + 1 > 9) ? LEN_W + 1 : 9;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_COUNT  = 2'd2;

	localparam logic [1:0] STS_DONE         = 2'd0;
	localparam logic [1:0] STS_RANGE        = 2'd1;
	localparam logic [1:0] STS_FULL         = 2'd2;
	localparam logic [1:0] STS_REMOVED_LAST = 2'd3;

	typedef struct packed {
		logic        [1:0]  mode;
		logic        [7:0]  position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] match_count;
		logic [8:0] length;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic step;
		logic wr_val;
		logic result;
	} dp_cmd_t;

	typedef struct packed {
		logic ok;
		logic scan;
		logic is_ins;
		logic last;
		logic out_busy;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/plirc_ctrl.sv =====
// Sequencer of the positional list: one operation at a time.
// Depends on plirc_pkg.
`default_nettype none

module plirc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire plirc_pkg::dp_sts_t sts,
	output plirc_pkg::dp_cmd_t      cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_RUN    = 3'd2;
	localparam logic [2:0] S_DRAIN  = 3'd3;
	localparam logic [2:0] S_WRVAL  = 3'd4;
	localparam logic [2:0] S_RESULT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				if (!sts.ok)         state_d = S_RESULT;
				else if (sts.scan)   state_d = S_RUN;
				else if (sts.is_ins) state_d = S_WRVAL;
				else                 state_d = S_RESULT;
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (sts.last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = sts.is_ins ? S_WRVAL : S_RESULT;
			end
			S_WRVAL: begin
				cmd.wr_val = 1'b1;
				state_d    = S_RESULT;
			end
			S_RESULT: begin
				if (!sts.out_busy) begin
					cmd.result = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

`default_nettype wire

// ===== rtl/plirc_dp.sv =====
// Datapath of the positional list: entry memory, shift/scan cursor,
// match counter, length and result register. Depends on plirc_pkg.
`default_nettype none

`include "positional_list_insert_remove_count_defines.svh"

module plirc_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire plirc_pkg::req_t    req,
	input  wire plirc_pkg::dp_cmd_t cmd,
	output plirc_pkg::dp_sts_t      sts,
	output plirc_pkg::rsp_t         rsp,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready
);

	localparam int IDX_W = plirc_pkg::IDX_W;
	localparam int LEN_W = plirc_pkg::LEN_W;
	localparam int CMP_W = plirc_pkg::CMP_W;

	logic        [1:0]       mode_q;
	logic        [7:0]       pos_q;
	logic signed [31:0]      val_q;
	logic        [LEN_W-1:0] len_q;
	logic        [LEN_W-1:0] cnt_q;
	logic        [IDX_W-1:0] cursor_q;
	logic        [IDX_W-1:0] stop_q;
	logic                    rd_s1;
	logic        [IDX_W-1:0] addr_s1;
	logic signed [31:0]      rdata_s1;
	logic signed [31:0]      mem [plirc_pkg::DEPTH];

	logic [CMP_W-1:0] pos_w, len_w;
	logic             is_ins, is_rem, is_cnt, full, ok, scan;
	logic [IDX_W-1:0] start_idx, stop_idx;
	logic [1:0]       err_code, status;
	logic [LEN_W-1:0] new_len;

	assign pos_w  = CMP_W'(pos_q);
	assign len_w  = CMP_W'(len_q);
	assign is_ins = (mode_q == plirc_pkg::MODE_INSERT);
	assign is_rem = (mode_q == plirc_pkg::MODE_REMOVE);
	assign is_cnt = (mode_q == plirc_pkg::MODE_COUNT);
	assign full   = (len_q == LEN_W'(plirc_pkg::DEPTH));

	// operation check and scan range
	always_comb begin
		ok        = 1'b1;
		scan      = 1'b0;
		err_code  = plirc_pkg::STS_RANGE;
		start_idx = '0;
		stop_idx  = '0;
		case (mode_q)
			plirc_pkg::MODE_INSERT: begin
				if (full) begin
					ok       = 1'b0;
					err_code = plirc_pkg::STS_FULL;
				end else if (pos_w == '0 || pos_w > len_w + CMP_W'(1)) begin
					ok = 1'b0;
				end else begin
					// shift down from the tail to the insert slot
					scan      = (pos_w <= len_w);
					start_idx = IDX_W'(len_w - CMP_W'(1));
					stop_idx  = IDX_W'(pos_w - CMP_W'(1));
				end
			end
			plirc_pkg::MODE_REMOVE: begin
				if (pos_w == '0 || pos_w > len_w) begin
					ok = 1'b0;
				end else begin
					scan      = (pos_w < len_w);
					start_idx = IDX_W'(pos_w);
					stop_idx  = IDX_W'(len_w - CMP_W'(1));
				end
			end
			plirc_pkg::MODE_COUNT: begin
				scan      = (len_q != '0);
				start_idx = '0;
				stop_idx  = IDX_W'(len_w - CMP_W'(1));
			end
			default: begin
				ok = 1'b1;
			end
		endcase
	end

	always_comb begin
		new_len = len_q;
		if (ok && is_ins) new_len = len_q + LEN_W'(1);
		if (ok && is_rem) new_len = len_q - LEN_W'(1);
		if (!ok)                             status = err_code;
		else if (is_rem && new_len == '0)    status = plirc_pkg::STS_REMOVED_LAST;
		else                                 status = plirc_pkg::STS_DONE;
	end

	assign sts.ok       = ok;
	assign sts.scan     = scan;
	assign sts.is_ins   = is_ins;
	assign sts.last     = (cursor_q == stop_q);
	assign sts.out_busy = rsp_valid && !rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			rd_s1     <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			rd_s1 <= cmd.step;
			if (cmd.result) begin
				len_q     <= new_len;
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req.mode;
			pos_q  <= req.position;
			val_q  <= req.value;
			cnt_q  <= '0;
		end else if (rd_s1 && is_cnt && rdata_s1 == val_q) begin
			cnt_q <= cnt_q + LEN_W'(1);
		end
		if (cmd.decide) begin
			cursor_q <= start_idx;
			stop_q   <= stop_idx;
		end else if (cmd.step) begin
			cursor_q <= is_ins ? cursor_q - IDX_W'(1) : cursor_q + IDX_W'(1);
		end
		if (cmd.step) addr_s1 <= cursor_q;
		if (cmd.result) begin
			rsp.status      <= status;
			rsp.match_count <= is_cnt ? 9'(cnt_q) : 9'd0;
			rsp.length      <= 9'(new_len);
		end
	end

	// one read, one write per cycle; read data registered
	always_ff @(posedge clk) begin
		if (cmd.step) rdata_s1 <= mem[cursor_q];
		if (cmd.wr_val)            mem[IDX_W'(pos_q - 8'd1)] <= val_q;
		else if (rd_s1 && is_ins)  mem[addr_s1 + IDX_W'(1)]  <= rdata_s1;
		else if (rd_s1 && is_rem)  mem[addr_s1 - IDX_W'(1)]  <= rdata_s1;
	end

	`PLIRC_ASSERT_ALWAYS(a_len_bound, len_q <= LEN_W'(plirc_pkg::DEPTH), "length above depth")
	`PLIRC_ASSERT_IMPL(a_no_rw_clash, rd_s1 && cmd.step && is_ins, (addr_s1 + IDX_W'(1)) != cursor_q, "shift write hits read address")
	`PLIRC_ASSERT_IMPL(a_count_bound, rsp_valid, rsp.match_count <= rsp.length, "match count above length")
	`PLIRC_ASSERT_IMPL(a_empty_on_last, rsp_valid && rsp.status == plirc_pkg::STS_REMOVED_LAST, rsp.length == 9'd0, "last removal leaves entries")

endmodule

`default_nettype wire

// ===== rtl/positional_list_insert_remove_count.sv =====
// Positional list block, top level: sequencer plus datapath.
// Depends on plirc_pkg, plirc_ctrl and plirc_dp.
//
// Usage
//   req channel (req_valid/req_ready/req): one beat is one operation:
//   insert a value at a 1-based position, remove the entry at a position,
//   or count entries equal to a value.
//   rsp channel (rsp_valid/rsp_ready/rsp): exactly one beat per request,
//   in request order, carrying status, match count and the new length.
//
// Sequence
//   One operation is in flight at a time. A request is accepted and
//   decided, takes one run step per entry moved or scanned, drains the read
//   pipeline when any entry is read and writes the new value on insert:
//     insert at p: len - p + 1 moves
//     remove at p: len - p moves
//     count      : len compares
//   The scan through the entry memory does one read and one write a cycle;
//   a count over a full list compares all 16 entries. The result comes last.
//   Rejected requests go from the decide step straight to the result.
//
// Reset clears the length to zero and empties the result register; entry
// contents are left as they are and are never read before being written.
// A stalled receiver holds the result in the output register; the next
// request is accepted and worked on, and waits only at its own result.
`default_nettype none

module positional_list_insert_remove_count (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire plirc_pkg::req_t req,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output plirc_pkg::rsp_t      rsp
);

	plirc_pkg::dp_cmd_t cmd;
	plirc_pkg::dp_sts_t sts;

	plirc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	plirc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready)
	);

endmodule

`default_nettype wire
